>>> hdl/systematic_particle_resampler_core_macros.svh
// ----------------------------------------------------------------------------
// systematic particle resampler assertion macros
// concurrent assertion wrappers, empty when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef SYSTEMATIC_PARTICLE_RESAMPLER_CORE_MACROS_SVH
`define SYSTEMATIC_PARTICLE_RESAMPLER_CORE_MACROS_SVH

`ifndef SYNTHESIS
// property must hold at every clock edge out of reset
`define SPR_ASSERT_IMPL(lbl, clk, rst_n, prop) \
lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
	else $error("spr assertion failed");
// condition must never be seen at a clock edge out of reset
`define SPR_ASSERT_NEVER(lbl, clk, rst_n, cond) \
lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
	else $error("spr forbidden condition seen");
`else
`define SPR_ASSERT_IMPL(lbl, clk, rst_n, prop)
`define SPR_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

>>> hdl/spr_pkg.sv
// ----------------------------------------------------------------------------
// spr_pkg
// shared widths, constants and controller/datapath interface structs
// ----------------------------------------------------------------------------
package spr_pkg;

	localparam int POS_W   = 16;              // q8.8 position
	localparam int W_W     = 17;              // q1.16 weight
	localparam int FRAC_W  = 16;              // random start fraction
	localparam int CFG_W   = 7;               // particle_count register
	localparam int SRC_W   = 6;               // source_index port
	localparam int SUM_W   = 23;              // weight sums
	localparam int PROD_W  = 2 * W_W;         // weight times numerator
	localparam int ACC_W   = 30;              // walk compare width
	localparam int DCNT_W  = $clog2(W_W);     // divider step counter

	localparam logic [W_W-1:0] ONE = 17'h10000;  // 1.0 in q1.16

	// controller to datapath commands
	typedef struct packed {
		logic accept;
		logic idx_inc;
		logic rs_mul;
		logic div_init;
		logic div_step;
		logic rs_write;
		logic walk_init;
		logic wk_mul;
		logic wk_add;
		logic emit;
		logic round_done;
	} cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic usum_zero;
		logic flag;
		logic div_last;
		logic idx_last;
		logic advance;
		logic m_last;
		logic out_free;
	} sts_t;

endpackage

>>> hdl/spr_datapath.sv
// ----------------------------------------------------------------------------
// spr_datapath
// particle stores, weight sums, rescale divider, cumulative walk, result reg
// ----------------------------------------------------------------------------
`include "systematic_particle_resampler_core_macros.svh"

module spr_datapath #(
	parameter int MAX_PARTICLES = 64
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  spr_pkg::cmd_t                   cmd,
	output spr_pkg::sts_t                   sts,
	input  logic                            cfg_wr_en,
	input  logic [spr_pkg::CFG_W-1:0]       cfg_wr_data,
	input  logic signed [spr_pkg::POS_W-1:0] x_pos,
	input  logic signed [spr_pkg::POS_W-1:0] y_pos,
	input  logic [spr_pkg::W_W-1:0]         weight,
	input  logic                            sensor_updated,
	input  logic [spr_pkg::FRAC_W-1:0]      rand_fraction,
	input  logic                            last_particle,
	input  logic                            result_stall,
	output logic                            result_valid,
	output logic signed [spr_pkg::POS_W-1:0] out_x,
	output logic signed [spr_pkg::POS_W-1:0] out_y,
	output logic [spr_pkg::SRC_W-1:0]       source_index,
	output logic                            out_last
);
	import spr_pkg::*;

	localparam int IDX_W = $clog2(MAX_PARTICLES);
	localparam int CNT_W = $clog2(MAX_PARTICLES + 1);

	// particle stores
	logic [POS_W-1:0] x_mem [MAX_PARTICLES];
	logic [POS_W-1:0] y_mem [MAX_PARTICLES];
	logic [W_W-1:0]   w_mem [MAX_PARTICLES];
	logic             f_mem [MAX_PARTICLES];

	logic [POS_W-1:0] x_rd_q, y_rd_q;
	logic [W_W-1:0]   w_rd_q;
	logic             f_rd_q;

	logic [CNT_W-1:0] n_q, n_d;
	logic [CNT_W-1:0] load_cnt_q, count_q, m_q;
	logic [IDX_W-1:0] idx_q;
	logic [SUM_W-1:0] usum_q, psum_q;
	logic [FRAC_W-1:0] rand_q;
	logic [W_W-1:0]   numer_q;
	logic [PROD_W-1:0] prod_q;
	logic [SUM_W-1:0] rem_q;
	logic [W_W-1:0]   dq_q;
	logic [DCNT_W-1:0] div_cnt_q;
	logic [ACC_W-1:0] lhs_q, cn_q, wn_q;

	logic             store_en;
	logic             w_we;
	logic [IDX_W-1:0] w_wa;
	logic [W_W-1:0]   w_wd;
	logic [SUM_W:0]   div_shift;
	logic             div_ge;

	logic signed [POS_W-1:0] out_x_q, out_y_q;
	logic [SRC_W-1:0] src_q;
	logic             last_q, out_valid_q;

	// clamp the written count into the supported range
	always_comb begin
		priority if (cfg_wr_data < CFG_W'(2)) begin
			n_d = CNT_W'(2);
		end else if (cfg_wr_data > CFG_W'(MAX_PARTICLES)) begin
			n_d = CNT_W'(MAX_PARTICLES);
		end else begin
			n_d = CNT_W'(cfg_wr_data);
		end
	end

	assign store_en = cmd.accept && (load_cnt_q < n_q);

	assign w_we = store_en || cmd.rs_write;
	assign w_wa = store_en ? load_cnt_q[IDX_W-1:0] : idx_q;
	assign w_wd = store_en ? weight : dq_q;

	always_ff @(posedge clk) begin
		if (store_en) begin
			x_mem[load_cnt_q[IDX_W-1:0]] <= x_pos;
			y_mem[load_cnt_q[IDX_W-1:0]] <= y_pos;
			f_mem[load_cnt_q[IDX_W-1:0]] <= sensor_updated;
		end
		if (w_we) begin
			w_mem[w_wa] <= w_wd;
		end
		x_rd_q <= x_mem[idx_q];
		y_rd_q <= y_mem[idx_q];
		w_rd_q <= w_mem[idx_q];
		f_rd_q <= f_mem[idx_q];
	end

	// restoring division step
	assign div_shift = {rem_q, dq_q[W_W-1]};
	assign div_ge    = div_shift >= {1'b0, usum_q};

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q         <= CNT_W'(MAX_PARTICLES);
			load_cnt_q  <= '0;
			usum_q      <= '0;
			psum_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				n_q <= n_d;
			end
			if (store_en) begin
				if (sensor_updated) begin
					usum_q <= usum_q + SUM_W'(weight);
				end else begin
					psum_q <= psum_q + SUM_W'(weight);
				end
			end
			// the last transaction of a set rewinds the fill count
			if (cmd.accept && last_particle) begin
				load_cnt_q <= '0;
			end
			if (store_en && !last_particle) begin
				load_cnt_q <= load_cnt_q + CNT_W'(1);
			end
			if (cmd.round_done) begin
				usum_q <= '0;
				psum_q <= '0;
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		numer_q <= (psum_q >= SUM_W'(ONE)) ? '0 : W_W'(SUM_W'(ONE) - psum_q);
		if (cmd.accept && last_particle) begin
			count_q <= store_en ? load_cnt_q + CNT_W'(1) : load_cnt_q;
			rand_q  <= rand_fraction;
			idx_q   <= '0;
		end
		if (cmd.idx_inc) begin
			idx_q <= idx_q + IDX_W'(1);
		end
		if (cmd.rs_mul) begin
			prod_q <= PROD_W'(w_rd_q) * PROD_W'(numer_q);
		end
		if (cmd.div_init) begin
			rem_q     <= SUM_W'(prod_q[PROD_W-1:W_W]);
			dq_q      <= prod_q[W_W-1:0];
			div_cnt_q <= '0;
		end
		if (cmd.div_step) begin
			rem_q     <= div_ge ? SUM_W'(div_shift - {1'b0, usum_q}) : div_shift[SUM_W-1:0];
			dq_q      <= {dq_q[W_W-2:0], div_ge};
			div_cnt_q <= div_cnt_q + DCNT_W'(1);
		end
		if (cmd.walk_init) begin
			idx_q <= '0;
			m_q   <= '0;
			lhs_q <= ACC_W'(rand_q);
			cn_q  <= '0;
		end
		if (cmd.wk_mul) begin
			wn_q <= ACC_W'(w_rd_q) * ACC_W'(n_q);
		end
		if (cmd.wk_add) begin
			cn_q <= cn_q + wn_q;
		end
		if (cmd.emit) begin
			out_x_q <= x_rd_q;
			out_y_q <= y_rd_q;
			src_q   <= SRC_W'(idx_q);
			last_q  <= sts.m_last;
			m_q     <= m_q + CNT_W'(1);
			lhs_q   <= lhs_q + ACC_W'(ONE);
		end
	end

	assign sts.usum_zero = (usum_q == '0);
	assign sts.flag      = f_rd_q;
	assign sts.div_last  = (div_cnt_q == DCNT_W'(W_W - 1));
	assign sts.idx_last  = ((CNT_W'(idx_q) + CNT_W'(1)) == count_q);
	assign sts.advance   = (lhs_q > cn_q) && ((CNT_W'(idx_q) + CNT_W'(1)) < count_q);
	assign sts.m_last    = ((m_q + CNT_W'(1)) == n_q);
	assign sts.out_free  = !out_valid_q || !result_stall;

	assign result_valid = out_valid_q;
	assign out_x        = out_x_q;
	assign out_y        = out_y_q;
	assign source_index = src_q;
	assign out_last     = last_q;

	`SPR_ASSERT_NEVER(a_emit_overwrite, clk, arst_n, cmd.emit && result_valid && result_stall)
	`SPR_ASSERT_NEVER(a_walk_in_range, clk, arst_n, cmd.wk_mul && (CNT_W'(idx_q) >= count_q))
	`SPR_ASSERT_IMPL(a_stall_holds, clk, arst_n, result_valid && result_stall |=> result_valid && $stable(out_x) && $stable(source_index))

endmodule

>>> hdl/spr_controller.sv
// ----------------------------------------------------------------------------
// spr_controller
// sequences load, weight rescale and the resampling walk
// ----------------------------------------------------------------------------
`include "systematic_particle_resampler_core_macros.svh"

module spr_controller (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          item_valid,
	input  logic          last_particle,
	output logic          item_stall,
	input  spr_pkg::sts_t sts,
	output spr_pkg::cmd_t cmd
);
	import spr_pkg::*;

	typedef enum logic [11:0] {
		ST_LOAD     = 12'b0000_0000_0001,
		ST_START    = 12'b0000_0000_0010,
		ST_RS_RD    = 12'b0000_0000_0100,
		ST_RS_MUL   = 12'b0000_0000_1000,
		ST_RS_DINIT = 12'b0000_0001_0000,
		ST_RS_DIV   = 12'b0000_0010_0000,
		ST_RS_WR    = 12'b0000_0100_0000,
		ST_WK_INIT  = 12'b0000_1000_0000,
		ST_WK_RD    = 12'b0001_0000_0000,
		ST_WK_MUL   = 12'b0010_0000_0000,
		ST_WK_ADD   = 12'b0100_0000_0000,
		ST_WK_CMP   = 12'b1000_0000_0000
	} state_t;

	state_t state_q, state_d;

	assign item_stall = (state_q != ST_LOAD);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			ST_LOAD: begin
				cmd.accept = item_valid;
				if (item_valid && last_particle) begin
					state_d = ST_START;
				end
			end
			ST_START: begin
				state_d = sts.usum_zero ? ST_WK_INIT : ST_RS_RD;
			end
			ST_RS_RD: begin
				state_d = ST_RS_MUL;
			end
			ST_RS_MUL: begin
				priority if (sts.flag) begin
					cmd.rs_mul = 1'b1;
					state_d    = ST_RS_DINIT;
				end else if (sts.idx_last) begin
					state_d = ST_WK_INIT;
				end else begin
					cmd.idx_inc = 1'b1;
					state_d     = ST_RS_RD;
				end
			end
			ST_RS_DINIT: begin
				cmd.div_init = 1'b1;
				state_d      = ST_RS_DIV;
			end
			ST_RS_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_d = ST_RS_WR;
				end
			end
			ST_RS_WR: begin
				cmd.rs_write = 1'b1;
				if (sts.idx_last) begin
					state_d = ST_WK_INIT;
				end else begin
					cmd.idx_inc = 1'b1;
					state_d     = ST_RS_RD;
				end
			end
			ST_WK_INIT: begin
				cmd.walk_init = 1'b1;
				state_d       = ST_WK_RD;
			end
			ST_WK_RD: begin
				state_d = ST_WK_MUL;
			end
			ST_WK_MUL: begin
				cmd.wk_mul = 1'b1;
				state_d    = ST_WK_ADD;
			end
			ST_WK_ADD: begin
				cmd.wk_add = 1'b1;
				state_d    = ST_WK_CMP;
			end
			ST_WK_CMP: begin
				priority if (sts.advance) begin
					cmd.idx_inc = 1'b1;
					state_d     = ST_WK_RD;
				end else if (sts.out_free) begin
					cmd.emit = 1'b1;
					if (sts.m_last) begin
						cmd.round_done = 1'b1;
						state_d        = ST_LOAD;
					end
				end
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	`SPR_ASSERT_IMPL(a_round_returns, clk, arst_n, cmd.round_done |=> (state_q == ST_LOAD))
	`SPR_ASSERT_NEVER(a_emit_not_advance, clk, arst_n, cmd.emit && cmd.idx_inc)

endmodule

>>> hdl/systematic_particle_resampler_core.sv
// ----------------------------------------------------------------------------
// systematic_particle_resampler_core
// low-variance resampler: loads a particle set, rescales sensor weights,
// then emits N resampled copies
// ----------------------------------------------------------------------------
// usage:
//   item channel (item_valid / item_stall) loads one particle per cycle while
//   the block is in its load phase; the transaction flagged last_particle
//   closes the set and latches rand_fraction
//   result channel (result_valid / result_stall) then gives particle_count
//   transactions, out_last set on the final one
//   rescale, skipped when the updated weights sum to zero: each particle is
//   read from the store, an updated one then takes one multiply and a
//   17-step serial divider; the walk steps to the next particle by store
//   read, multiply, add and compare, and emits from the compare state
//   item_stall stays high from the last item until the last result is
//   registered; the next set may load while that result waits
//   a stalled result holds in the output register and the walk pauses
//   once it reaches the next result to emit
//   reset: count register returns to MAX_PARTICLES, sums and fill count
//   clear, particle stores keep whatever they held
//   particle_count writes go through cfg_wr_en / cfg_wr_data while idle
// ----------------------------------------------------------------------------
module systematic_particle_resampler_core #(
	parameter int MAX_PARTICLES = 64
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// configuration
	input  logic                             cfg_wr_en,
	input  logic [spr_pkg::CFG_W-1:0]        cfg_wr_data,
	// item channel
	input  logic                             item_valid,
	output logic                             item_stall,
	input  logic signed [spr_pkg::POS_W-1:0] x_pos,
	input  logic signed [spr_pkg::POS_W-1:0] y_pos,
	input  logic [spr_pkg::W_W-1:0]          weight,
	input  logic                             sensor_updated,
	input  logic [spr_pkg::FRAC_W-1:0]       rand_fraction,
	input  logic                             last_particle,
	// result channel
	output logic                             result_valid,
	input  logic                             result_stall,
	output logic signed [spr_pkg::POS_W-1:0] out_x,
	output logic signed [spr_pkg::POS_W-1:0] out_y,
	output logic [spr_pkg::SRC_W-1:0]        source_index,
	output logic                             out_last
);
	import spr_pkg::*;

	// command and status between sequencer and datapath
	cmd_t cmd;
	sts_t sts;

	// sequencer: load phase, per-particle rescale, walk with result handoff
	spr_controller u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.item_valid    (item_valid),
		.last_particle (last_particle),
		.item_stall    (item_stall),
		.sts           (sts),
		.cmd           (cmd)
	);

	// stores, sums, serial divider, cumulative compare and result register
	spr_datapath #(
		.MAX_PARTICLES (MAX_PARTICLES)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data),
		.x_pos          (x_pos),
		.y_pos          (y_pos),
		.weight         (weight),
		.sensor_updated (sensor_updated),
		.rand_fraction  (rand_fraction),
		.last_particle  (last_particle),
		.result_stall   (result_stall),
		.result_valid   (result_valid),
		.out_x          (out_x),
		.out_y          (out_y),
		.source_index   (source_index),
		.out_last       (out_last)
	);

endmodule
